// File: hw/rtl/kcc_pkg.sv
// Shared types and constants for the k-means color clustering unit.
// No dependencies.
package kcc_pkg;
	localparam int KCC_MAX_CENTERS = 16;
	localparam int KCC_MAX_PIXELS  = 4096;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam logic [4:0] CC_RESET = 5'd4;
	localparam logic [6:0] MS_RESET = 7'd100;
	localparam logic [15:0] SEED_RESET = 16'd1;
	localparam logic [1:0] REG_CENTER_COUNT = 2'd0;
	localparam logic [1:0] REG_MAX_STEPS = 2'd1;
	localparam logic [1:0] REG_LFSR_SEED = 2'd2;
	localparam logic OP_CENTER = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_CLR, CMD_ASSIGN, CMD_UPD_START, CMD_UPD_STEP, CMD_EMIT
	} kcc_cmd_e_t;

	typedef struct packed {
		kcc_cmd_e_t cmd;
		logic       store_px;   // write pixel on input transaction
		logic       load_ctr;
	} kcc_ctl_t;

	typedef struct packed {
		logic assign_done;   // all pixels assigned
		logic upd_done;      // all centers updated
		logic all_same;
		logic emit_done;
	} kcc_sts_t;

	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		logic [15:0] n;
		n = {1'b0, v[15:1]};
		if (v[0]) n = n ^ LFSR_TAPS;
		return n;
	endfunction
endpackage

// File: hw/rtl/kcc_divider.sv
// Restoring divider: 21-bit dividend by 13-bit divisor, one quotient bit per cycle.
// Uses kcc_pkg.
module kcc_divider import kcc_pkg::*; #(
	parameter int NW = 21,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [7:0]    quot
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   trial;

	always_comb begin
		trial = {rem_q[DW-1:0], q_q[NW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q[7:0];
endmodule

// File: hw/rtl/kcc_datapath.sv
// Datapath: pixel memory, centers, accumulators, nearest-center search and mean update.
// Uses kcc_pkg and kcc_divider.
module kcc_datapath import kcc_pkg::*; #(
	parameter int MAX_CENTERS = KCC_MAX_CENTERS,
	parameter int MAX_PIXELS  = KCC_MAX_PIXELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  kcc_ctl_t    ctl,
	output kcc_sts_t    sts,
	input  logic [3:0]  center_index,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic [4:0]  k_eff,
	input  logic        seed_wr,
	input  logic [15:0] seed_val,
	input  logic        run_end,
	output logic        full,
	output logic [3:0]  result_index,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic        last_center
);
	localparam int CI = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int PI = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int PC = $clog2(MAX_PIXELS + 1);
	localparam int SW = PC + 8;
	localparam int KW = $clog2(MAX_CENTERS + 1);

	logic [23:0] mem [MAX_PIXELS];
	logic [23:0] rd_s1;
	logic [PC-1:0] total_q;
	logic [23:0] ctr_q [MAX_CENTERS];
	logic [SW-1:0] sb_q [MAX_CENTERS];
	logic [SW-1:0] sg_q [MAX_CENTERS];
	logic [SW-1:0] sr_q [MAX_CENTERS];
	logic [PC-1:0] cnt_q [MAX_CENTERS];
	logic [15:0] lfsr_q;

	// assignment: fetch address p, then search centers one per cycle
	logic [PC-1:0] pa_q;
	logic [KW-1:0] cs_q;
	logic [9:0] bestd_q;
	logic [CI-1:0] best_q;
	logic       rdv_s1, srch_q;
	logic [9:0] d;
	logic [7:0] cb, cg, cr;

	always_ff @(posedge clk) begin
		if (ctl.store_px && !full) mem[total_q[PI-1:0]] <= {blue, green, red};
		rd_s1 <= mem[pa_q[PI-1:0]];
	end

	assign full = (total_q == PC'(MAX_PIXELS));
	assign {cb, cg, cr} = ctr_q[cs_q[CI-1:0]];

	function automatic logic [7:0] ad(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		d = 10'(ad(rd_s1[23:16], cb)) + 10'(ad(rd_s1[15:8], cg)) + 10'(ad(rd_s1[7:0], cr));
	end

	// update: per center with members, three divisions in turn; an empty center is reseeded from the LFSR
	logic [KW-1:0] uc_q;
	logic [1:0] ch_q;
	logic div_go, div_done;
	logic [7:0] quot;
	logic [7:0] nb_q, ng_q;
	logic upd_run_q, same_q, upd_busy_q;
	logic [SW-1:0] num_sel;
	logic [CI-1:0] ui;

	assign ui = uc_q[CI-1:0];
	always_comb begin
		case (ch_q)
			2'd0: num_sel = sb_q[ui];
			2'd1: num_sel = sg_q[ui];
			default: num_sel = sr_q[ui];
		endcase
	end

	kcc_divider #(.NW(SW), .DW(PC)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(num_sel),
		.den(cnt_q[ui]), .done(div_done), .quot(quot)
	);

	logic [KW-1:0] ec_q;
	logic [15:0] l1, l2, l3;
	assign l1 = lfsr_step(lfsr_q);
	assign l2 = lfsr_step(l1);
	assign l3 = lfsr_step(l2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			lfsr_q <= SEED_RESET;
			srch_q <= 1'b0;
			rdv_s1 <= 1'b0;
			pa_q <= '0;
			cs_q <= '0;
			sts <= '0;
			upd_run_q <= 1'b0;
			upd_busy_q <= 1'b0;
			div_go <= 1'b0;
			ch_q <= '0;
			uc_q <= '0;
			same_q <= 1'b0;
			ec_q <= '0;
			last_center <= 1'b0;
		end else begin
			div_go <= 1'b0;
			sts.assign_done <= 1'b0;
			sts.upd_done <= 1'b0;
			sts.emit_done <= 1'b0;
			if (seed_wr) lfsr_q <= (seed_val == 16'd0) ? 16'd1 : seed_val;
			if (ctl.store_px && !full) total_q <= total_q + 1'b1;
			if (run_end) total_q <= '0;
			case (ctl.cmd)
				CMD_CLR: begin
					for (int i = 0; i < MAX_CENTERS; i++) cnt_q[i] <= '0;
					pa_q <= '0;
					rdv_s1 <= 1'b0;
					srch_q <= 1'b0;
				end
				CMD_ASSIGN: begin
					if (!srch_q && !rdv_s1) begin
						if (pa_q == total_q) sts.assign_done <= 1'b1;
						else rdv_s1 <= 1'b1;
					end else if (rdv_s1) begin
						rdv_s1 <= 1'b0;
						srch_q <= 1'b1;
						cs_q <= '0;
						bestd_q <= 10'h3FF;
					end else begin
						// strict less keeps lowest index on ties
						if (d < bestd_q || cs_q == '0) begin
							bestd_q <= d;
							best_q <= cs_q[CI-1:0];
						end
						if (cs_q == k_eff - 1'b1) begin
							srch_q <= 1'b0;
							pa_q <= pa_q + 1'b1;
						end else cs_q <= cs_q + 1'b1;
					end
					// accumulate the winner once the search closes
					if (srch_q && cs_q == k_eff - 1'b1) begin
						if (d < bestd_q || cs_q == '0) begin
							sb_q[cs_q[CI-1:0]] <= ((cnt_q[cs_q[CI-1:0]] == '0) ? '0 :
								sb_q[cs_q[CI-1:0]]) + SW'(rd_s1[23:16]);
							sg_q[cs_q[CI-1:0]] <= ((cnt_q[cs_q[CI-1:0]] == '0) ? '0 :
								sg_q[cs_q[CI-1:0]]) + SW'(rd_s1[15:8]);
							sr_q[cs_q[CI-1:0]] <= ((cnt_q[cs_q[CI-1:0]] == '0) ? '0 :
								sr_q[cs_q[CI-1:0]]) + SW'(rd_s1[7:0]);
							cnt_q[cs_q[CI-1:0]] <= cnt_q[cs_q[CI-1:0]] + 1'b1;
						end else begin
							sb_q[best_q] <= ((cnt_q[best_q] == '0) ? '0 : sb_q[best_q])
								+ SW'(rd_s1[23:16]);
							sg_q[best_q] <= ((cnt_q[best_q] == '0) ? '0 : sg_q[best_q])
								+ SW'(rd_s1[15:8]);
							sr_q[best_q] <= ((cnt_q[best_q] == '0) ? '0 : sr_q[best_q])
								+ SW'(rd_s1[7:0]);
							cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
						end
					end
				end
				CMD_UPD_START: begin
					uc_q <= '0;
					ch_q <= '0;
					same_q <= 1'b1;
					upd_run_q <= 1'b1;
					upd_busy_q <= 1'b0;
				end
				CMD_UPD_STEP: begin
					if (upd_run_q) begin
						if (uc_q == k_eff) begin
							upd_run_q <= 1'b0;
							sts.upd_done <= 1'b1;
							sts.all_same <= same_q;
						end else if (cnt_q[ui] == '0) begin
							ctr_q[ui] <= {l1[7:0], l2[7:0], l3[7:0]};
							lfsr_q <= l3;
							same_q <= 1'b0;
							uc_q <= uc_q + 1'b1;
						end else if (!upd_busy_q) begin
							div_go <= 1'b1;
							upd_busy_q <= 1'b1;
						end else if (div_done) begin
							upd_busy_q <= 1'b0;
							case (ch_q)
								2'd0: begin nb_q <= quot; ch_q <= 2'd1; end
								2'd1: begin ng_q <= quot; ch_q <= 2'd2; end
								default: begin
									if (ctr_q[ui] != {nb_q, ng_q, quot}) same_q <= 1'b0;
									ctr_q[ui] <= {nb_q, ng_q, quot};
									ch_q <= 2'd0;
									uc_q <= uc_q + 1'b1;
								end
							endcase
						end
					end
				end
				CMD_EMIT: begin
					// hold the outputs once the last center has gone out
					if (!sts.emit_done) begin
						last_center <= (ec_q == k_eff - 1'b1);
						result_index <= 4'(ec_q);
						{out_blue, out_green, out_red} <= ctr_q[ec_q[CI-1:0]];
						if (ec_q == k_eff - 1'b1) begin
							ec_q <= '0;
							sts.emit_done <= 1'b1;
						end else ec_q <= ec_q + 1'b1;
					end
				end
				default: begin
					ec_q <= '0;
				end
			endcase
			if (ctl.load_ctr && 32'(center_index) < MAX_CENTERS)
				ctr_q[center_index[CI-1:0]] <= {blue, green, red};
		end
	end
endmodule

// File: hw/rtl/kcc_ctrl.sv
// Controller state machine: load, assign, update, emit sequencing.
// Uses kcc_pkg.
module kcc_ctrl import kcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       op,
	input  logic       last,
	input  logic [6:0] limit,
	input  kcc_sts_t   sts,
	input  logic       full,
	output kcc_ctl_t   ctl,
	output logic       busy,
	output logic       done,
	output logic [6:0] steps_used,
	output logic       converged,
	output logic       overflow,
	output logic       run_end
);
	typedef enum logic [2:0] {S_IDLE, S_CLR, S_ASSIGN, S_UPD0, S_UPD, S_EMIT0, S_EMIT} st_t;
	st_t st_q;
	logic acc;
	logic ovf_q;

	assign acc = start && !busy;
	assign busy = (st_q != S_IDLE);
	// clear the pixel count on the same edge that returns to idle
	assign run_end = (st_q == S_EMIT) && sts.emit_done;
	always_comb begin
		ctl.store_px = acc && (op == OP_PIXEL);
		ctl.load_ctr = acc && (op == OP_CENTER);
		case (st_q)
			S_CLR:   ctl.cmd = CMD_CLR;
			S_ASSIGN: ctl.cmd = CMD_ASSIGN;
			S_UPD0:  ctl.cmd = CMD_UPD_START;
			S_UPD:   ctl.cmd = CMD_UPD_STEP;
			S_EMIT:  ctl.cmd = CMD_EMIT;
			default: ctl.cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ovf_q <= 1'b0;
			steps_used <= '0;
			converged <= 1'b0;
			overflow <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= (st_q == S_EMIT) && !sts.emit_done;
			case (st_q)
				S_IDLE: begin
					if (ctl.store_px) begin
						if (full) ovf_q <= 1'b1;
						if (last) begin
							st_q <= S_CLR;
							steps_used <= '0;
							overflow <= ovf_q || full;
						end
					end
				end
				S_CLR: begin
					steps_used <= steps_used + 1'b1;
					st_q <= S_ASSIGN;
				end
				S_ASSIGN: if (sts.assign_done) st_q <= S_UPD0;
				S_UPD0: st_q <= S_UPD;
				S_UPD: begin
					if (sts.upd_done) begin
						converged <= sts.all_same;
						if (sts.all_same || steps_used >= limit) st_q <= S_EMIT;
						else st_q <= S_CLR;
					end
				end
				S_EMIT: begin
					if (sts.emit_done) begin
						st_q <= S_IDLE;
						ovf_q <= 1'b0;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/kmeans_color_clustering_unit.sv
// K-means color clustering unit, top level.
// Loads are taken back to back while the unit is idle. After the last pixel each iteration
// assigns every pixel, comparing one center per cycle, then updates each center with members
// by a serial divider per channel (SW = 21 bits by default) or reseeds it when it has none.
// Emission gives k strobes on consecutive cycles. The receiver cannot stall.
// Reset clears control, registers to defaults; pixel and center stores are not cleared.
module kmeans_color_clustering_unit import kcc_pkg::*; #(
	parameter int MAX_CENTERS = KCC_MAX_CENTERS,
	parameter int MAX_PIXELS  = KCC_MAX_PIXELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        op,
	input  logic [3:0]  center_index,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        last,
	output logic        result_valid,
	output logic [3:0]  result_index,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic [6:0]  steps_used,
	output logic        converged,
	output logic        overflow,
	output logic        last_center
);
	logic [4:0] cc_q;
	logic [6:0] ms_q;
	logic [4:0] k_eff;
	logic [6:0] limit;
	kcc_ctl_t ctl;
	kcc_sts_t sts;
	logic full, run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_RESET;
			ms_q <= MS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CENTER_COUNT) cc_q <= cfg_data[4:0];
			if (cfg_index == REG_MAX_STEPS) ms_q <= cfg_data[6:0];
		end
	end

	assign k_eff = (cc_q == '0) ? 5'd1 :
		(32'(cc_q) > MAX_CENTERS) ? 5'(MAX_CENTERS) : cc_q;
	assign limit = (ms_q == '0) ? 7'd1 : ms_q;

	kcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .last(last),
		.limit(limit), .sts(sts), .full(full), .ctl(ctl), .busy(busy),
		.done(result_valid), .steps_used(steps_used), .converged(converged),
		.overflow(overflow), .run_end(run_end)
	);

	kcc_datapath #(.MAX_CENTERS(MAX_CENTERS), .MAX_PIXELS(MAX_PIXELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.center_index(center_index), .blue(blue), .green(green), .red(red),
		.k_eff(k_eff), .seed_wr(cfg_we && cfg_index == REG_LFSR_SEED),
		.seed_val(cfg_data), .run_end(run_end), .full(full),
		.result_index(result_index), .out_blue(out_blue), .out_green(out_green),
		.out_red(out_red), .last_center(last_center)
	);
endmodule
